// ===== rtl/core/oahm_pkg.sv =====
// Shared types and constants for the open-addressing hash map.
package oahm_pkg;

  // Width of the load limit register and its value after reset.
  localparam int unsigned LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 6'd48;

  // Request operation codes.
  typedef enum logic [1:0] {
    MODE_GET = 2'd0,
    MODE_SET = 2'd1,
    MODE_DEL = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_HIT      = 2'd0,
    STAT_ABSENT   = 2'd1,
    STAT_INSERTED = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Occupancy of one slot.
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_st_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

  // Input beat.
  typedef struct packed {
    mode_t       mode;
    logic [63:0] key;
    logic [63:0] set_value;
  } in_t;

  // Output beat.
  typedef struct packed {
    status_t     status;
    logic [63:0] read_value;
  } out_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    slot_st_t    st;
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

endpackage

// ===== rtl/core/open_addressing_hash_map.sv =====
// Top level of the open-addressing hash map with linear probing and tombstones.
//
//   channel   signals                      direction  beat
//   in        in_valid in_stall in_data    input      mode, key, set_value
//   out       out_valid out_stall out_data output     status, read_value
//   cfg       cfg_we cfg_data              input      load_limit write
//
// After reset the slot memory is cleared, one slot a cycle.
// A request walks the probe from its home slot; the single slot memory
// read port gives one slot a cycle.
// When SLOTS is not a power of two the home slot comes from a long division, in state S_HASH.
// A result waits in the output register while the next request is probed;
// the block stalls its input whenever it is not idle, during the clearing pass too.
module open_addressing_hash_map #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  oahm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output oahm_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [oahm_pkg::LIMIT_W-1:0]     cfg_data
);

  import oahm_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = (IW + 1 > LIMIT_W) ? IW + 1 : LIMIT_W;

  state_t             state, state_next;
  logic [IW-1:0]      idx, idx_next;
  logic [IW-1:0]      n, n_next;
  logic               have_tomb, have_tomb_next;
  logic [IW-1:0]      tomb, tomb_next;
  logic [IW-1:0]      clr, clr_next;
  logic [IW-1:0]      used, used_next;
  logic [LIMIT_W-1:0] load_limit;
  in_t                req, req_next;
  out_t               res, res_next;
  logic               out_valid_next;
  out_t               out_data_next;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  slot_t              mem_wdata;
  logic [$bits(slot_t)-1:0] mem_rdata;
  slot_t              rd_slot;

  logic               home_start;
  logic               home_done;
  logic [IW-1:0]      home_idx;

  logic               is_empty, is_live, hit, last, probe_end;
  logic               tomb_seen;
  logic [IW-1:0]      tomb_at, where, idx_inc;
  logic               can_put, via_tomb, room;
  logic [CW-1:0]      used_p1;
  logic               accept;

  // Slot memory holding status, key and value of each slot.
  oahm_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx_next),
    .rdata(mem_rdata)
  );

  assign rd_slot = slot_t'(mem_rdata);

  // Home slot of the incoming key.
  oahm_home #(
    .SLOTS(SLOTS)
  ) u_home (
    .clk  (clk),
    .rst  (rst),
    .start(home_start),
    .key  (in_data.key),
    .done (home_done),
    .idx  (home_idx)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Decode of the slot read this cycle, which is always the slot at idx.
  always_comb begin
    is_empty  = (rd_slot.st == SLOT_EMPTY);
    is_live   = (rd_slot.st == SLOT_LIVE);
    hit       = is_live && (rd_slot.key == req.key);
    last      = (n == IW'(SLOTS - 1));
    probe_end = is_empty || hit || last;
    tomb_seen = have_tomb || (!is_empty && !is_live);
    tomb_at   = have_tomb ? tomb : idx;
    via_tomb  = is_empty ? have_tomb : tomb_seen;
    can_put   = !hit && (is_empty || tomb_seen);
    where     = hit ? idx : (via_tomb ? tomb_at : idx);
    idx_inc   = (idx == IW'(SLOTS - 1)) ? '0 : idx + 1'b1;
    used_p1   = CW'(used) + 1'b1;
    room      = (used_p1 <= CW'(load_limit)) && (used_p1 <= CW'(SLOTS - 1));
  end

  // Sequencer: clearing pass, home slot, probe walk, result hand-off.
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    n_next         = n;
    have_tomb_next = have_tomb;
    tomb_next      = tomb;
    clr_next       = clr;
    used_next      = used;
    req_next       = req;
    res_next       = res;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_waddr      = where;
    mem_wdata      = '{st: SLOT_LIVE, key: req.key, value: req.set_value};
    home_start     = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = '{st: SLOT_EMPTY, key: '0, value: '0};
        clr_next  = clr + 1'b1;
        if (clr == IW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_next       = in_data;
          n_next         = '0;
          have_tomb_next = 1'b0;
          case (in_data.mode)
            MODE_GET, MODE_SET, MODE_DEL: begin
              home_start = 1'b1;
              if (home_done) begin
                idx_next   = home_idx;
                state_next = S_PROBE;
              end else begin
                state_next = S_HASH;
              end
            end
            default: begin
              res_next   = '{status: STAT_ABSENT, read_value: '0};
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_HASH: begin
        if (home_done) begin
          idx_next   = home_idx;
          state_next = S_PROBE;
        end
      end

      S_PROBE: begin
        if (probe_end) begin
          state_next = S_DONE;
          res_next   = '{status: STAT_ABSENT, read_value: '0};
          case (req.mode)
            MODE_GET: begin
              if (hit) begin
                res_next = '{status: STAT_HIT, read_value: rd_slot.value};
              end
            end
            MODE_SET: begin
              if (hit) begin
                mem_we          = 1'b1;
                res_next.status = STAT_HIT;
              end else if (can_put && via_tomb) begin
                mem_we          = 1'b1;
                res_next.status = STAT_INSERTED;
              end else if (can_put && room) begin
                mem_we          = 1'b1;
                used_next       = used_p1[IW-1:0];
                res_next.status = STAT_INSERTED;
              end else begin
                res_next.status = STAT_FULL;
              end
            end
            MODE_DEL: begin
              if (hit) begin
                mem_we          = 1'b1;
                mem_wdata       = '{st: SLOT_TOMB, key: rd_slot.key, value: rd_slot.value};
                res_next.status = STAT_HIT;
              end
            end
            default: begin
              res_next.status = STAT_ABSENT;
            end
          endcase
        end else begin
          idx_next       = idx_inc;
          n_next         = n + 1'b1;
          have_tomb_next = tomb_seen;
          tomb_next      = tomb_at;
        end
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      used      <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      n         <= '0;
      have_tomb <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      used      <= used_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
      n         <= n_next;
      have_tomb <= have_tomb_next;
    end
    tomb     <= tomb_next;
    req      <= req_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  // Load limit register, writable at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      load_limit <= cfg_data;
    end
  end

`ifndef SYNTHESIS
  // The used count always leaves one empty slot so that a probe ends.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= IW'(SLOTS - 1))
    else $error("used slot count reached the table size");

  // The used count never falls and grows by at most one per request.
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (used == $past(used) || used == $past(used) + 1'b1))
    else $error("used slot count moved by an illegal amount");

  // A get never writes the slot memory.
  a_get_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && mem_we) |-> (req.mode != MODE_GET))
    else $error("slot memory written during a get");

  // A result beat appears only after the sequencer finished a request.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("output beat without a finished request");
`endif

endmodule

// ===== rtl/core/oahm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module oahm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and read-first registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/oahm_home.sv =====
// Home slot unit: xor-folds the key and reduces it modulo the slot count.
module oahm_home #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [63:0]              key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] idx
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned HASH_W = 32;
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned DIGITS = HASH_W / DIGIT_W;
  localparam int unsigned CNT_W = $clog2(DIGITS);
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

  logic [HASH_W-1:0] fold;

  // The hash folds the two key halves together.
  assign fold = key[31:0] ^ key[63:32];

  if (POW2) begin : g_mask
    // A power-of-two table takes the low bits in the cycle of the request.
    assign done = start;
    assign idx  = fold[IW-1:0];
  end else begin : g_reduce
    logic [HASH_W-1:0] sh;
    logic [IW-1:0]     rem;
    logic [CNT_W-1:0]  cnt;
    logic              busy;
    logic [IW-1:0]     acc;
    logic [IW:0]       t;

    // Long division by the slot count, one byte of the hash per cycle.
    always_comb begin
      acc = rem;
      t   = '0;
      for (int b = 0; b < DIGIT_W; b++) begin
        t = {acc, sh[HASH_W-1-b]};
        if (t >= (IW+1)'(SLOTS)) begin
          t = t - (IW+1)'(SLOTS);
        end
        acc = t[IW-1:0];
      end
    end

    assign done = busy && (cnt == CNT_W'(DIGITS - 1));
    assign idx  = acc;

    // Shift register of remaining hash bits and the running remainder.
    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        sh   <= fold;
      end else if (busy) begin
        rem <= acc;
        sh  <= sh << DIGIT_W;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIGITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sim/open_addressing_hash_map_tb.sv =====
// Self-checking testbench for the open-addressing hash map: directed table, then random traffic.
`timescale 1ns / 1ps

module open_addressing_hash_map_tb;
  import oahm_pkg::*;

  localparam int unsigned SLOTS = 64;
  // A probe reads at most SLOTS slots, plus hash and result cycles, plus margin.
  localparam int DRAIN_CYCLES = 2 + SLOTS + 4 + 10;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_AT_RESULT = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  // The unused operation code: the block answers it as an absent key.
  localparam mode_t MODE_NONE = mode_t'(2'd3);

  typedef enum logic {ROW_REQ, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [LIMIT_W-1:0] limit;
    mode_t             mode;
    logic [63:0]       key;
    logic [63:0]       value;
    logic              typed;
    status_t           status;
    logic [63:0]       read_value;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // Typed expectation that travels with the beat on offer.
  logic req_typed = 1'b0;
  out_t req_want = '0;

  // Predictor state.
  slot_st_t slot_state [SLOTS] = '{default: SLOT_EMPTY};
  logic [63:0] slot_key [SLOTS] = '{default: '0};
  logic [63:0] slot_value [SLOTS] = '{default: '0};
  int used_count = 0;
  int load_limit_now = LOAD_LIMIT_RESET;

  out_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int run_left = 0;
  logic [63:0] key_pool [32];

  // Directed stimulus: typed expectations only where they are plain to see.
  dir_row_t directed [26] = '{
    '{ROW_REQ, 6'd0, MODE_GET, 64'h0, 64'h0, 1'b1, STAT_ABSENT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'h0, ALL1, 1'b1, STAT_INSERTED, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, 64'h0, 64'h0, 1'b1, STAT_HIT, ALL1},
    '{ROW_REQ, 6'd0, MODE_SET, 64'h0, 64'h0, 1'b1, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, 64'h0, 64'h0, 1'b1, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, ALL1, 64'h0123_4567_89AB_CDEF, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, ALL1, 64'h0, 1'b1, STAT_HIT, 64'h0123_4567_89AB_CDEF},
    '{ROW_REQ, 6'd0, MODE_DEL, 64'h0, 64'h0, 1'b1, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, 64'h0, 64'h0, 1'b1, STAT_ABSENT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, ALL1, 64'h0, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'd64, 64'd5, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_DEL, 64'h0, 64'h0, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_NONE, 64'h5555_5555_5555_5555, ALL1, 1'b1, STAT_ABSENT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_DEL, ALL1, 64'h0, 1'b1, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, ALL1, 64'hFEDC_BA98_7654_3210, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
      STAT_HIT, 64'h0},
    '{ROW_LIMIT, 6'd3, MODE_GET, 64'h0, 64'h0, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'h1234, 64'd1, 1'b1, STAT_FULL, 64'h0},
    '{ROW_LIMIT, 6'd1, MODE_GET, 64'h0, 64'h0, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'h1234, 64'd1, 1'b1, STAT_FULL, 64'h0},
    '{ROW_LIMIT, 6'd0, MODE_GET, 64'h0, 64'h0, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'd64, ALL1, 1'b1, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_SET, 64'h77, 64'd2, 1'b1, STAT_FULL, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, 64'd64, 64'h0, 1'b1, STAT_HIT, ALL1},
    '{ROW_LIMIT, 6'd63, MODE_GET, 64'h0, 64'h0, 1'b0, STAT_HIT, 64'h0},
    '{ROW_REQ, 6'd0, MODE_GET, 64'h8000_0000_0000_0001, 64'h0, 1'b0, STAT_HIT, 64'h0}
  };

  logic [LIMIT_W-1:0] phase_limits [5] = '{6'd10, 6'd63, 6'd1, 6'd37, 6'd63};

  open_addressing_hash_map #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the predicted table and returns the expected result.
  function automatic out_t map_apply(in_t req);
    out_t res;
    logic [31:0] h;
    int idx;
    int where;
    int tomb;
    bit hit;
    bit can_put;
    bit via_tomb;
    bit have_tomb;
    bit done;
    res.status = STAT_ABSENT;
    res.read_value = '0;
    hit = 1'b0;
    can_put = 1'b0;
    via_tomb = 1'b0;
    have_tomb = 1'b0;
    done = 1'b0;
    tomb = 0;
    where = 0;
    if (req.mode == MODE_NONE) return res;

    // Walk from the home slot until an empty slot or the key itself.
    h = req.key[31:0] ^ req.key[63:32];
    idx = h % SLOTS;
    for (int n = 0; n < SLOTS && !done; n++) begin
      if (slot_state[idx] == SLOT_EMPTY) begin
        can_put = 1'b1;
        via_tomb = have_tomb;
        where = have_tomb ? tomb : idx;
        done = 1'b1;
      end else if (slot_state[idx] == SLOT_LIVE) begin
        if (slot_key[idx] == req.key) begin
          hit = 1'b1;
          where = idx;
          done = 1'b1;
        end
      end else if (!have_tomb) begin
        have_tomb = 1'b1;
        tomb = idx;
      end
      if (!done) idx = (idx + 1) % SLOTS;
    end
    if (!done && have_tomb) begin
      can_put = 1'b1;
      via_tomb = 1'b1;
      where = tomb;
    end

    case (req.mode)
      MODE_GET: begin
        if (hit) begin
          res.status = STAT_HIT;
          res.read_value = slot_value[where];
        end
      end
      MODE_SET: begin
        if (hit) begin
          slot_value[where] = req.set_value;
          res.status = STAT_HIT;
        end else if (can_put && (via_tomb ||
                     (used_count + 1 <= load_limit_now && used_count + 1 <= SLOTS - 1))) begin
          slot_state[where] = SLOT_LIVE;
          slot_key[where] = req.key;
          slot_value[where] = req.set_value;
          if (!via_tomb) used_count++;
          res.status = STAT_INSERTED;
        end else begin
          res.status = STAT_FULL;
        end
      end
      MODE_DEL: begin
        if (hit) begin
          slot_state[where] = SLOT_TOMB;
          res.status = STAT_HIT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Key whose home slot falls in the crowded region around the wrap point.
  function automatic logic [63:0] crowded_key();
    logic [31:0] hi;
    logic [31:0] mix;
    logic [5:0] homes [6];
    homes = '{6'd0, 6'd1, 6'd2, 6'd61, 6'd62, 6'd63};
    hi = $urandom;
    mix = $urandom;
    mix[5:0] = homes[$urandom_range(0, 5)];
    return {hi, hi ^ mix};
  endfunction

  function automatic in_t random_request();
    in_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.mode = (pick < 35) ? MODE_GET : (pick < 70) ? MODE_SET : (pick < 95) ? MODE_DEL : MODE_NONE;
    pick = $urandom_range(0, 9);
    if (pick == 0) r.key = {$urandom, $urandom};
    else if (pick == 1) r.key = crowded_key();
    else r.key = key_pool[$urandom_range(0, 31)];
    r.set_value = {$urandom, $urandom};
    return r;
  endfunction

  // Replaces part of the key pool so each phase sees fresh keys next to old ones.
  task automatic refresh_pool(int count);
    int slot;
    for (int i = 0; i < count; i++) begin
      slot = $urandom_range(0, 31);
      key_pool[slot] = $urandom_range(0, 1) ? crowded_key() : {$urandom, $urandom};
    end
  endtask

  // Offers one beat, after a random gap at the end of each burst, and waits for acceptance.
  task automatic offer(in_t req, logic typed, out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_data <= req;
    req_typed <= typed;
    req_want <= want;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
  endtask

  // Waits until every expected result has arrived and the block has gone quiet.
  task automatic drain();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] limit);
    in_valid <= 1'b0;
    drain();
    cfg_data <= limit;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result checking, limit tracking and prediction, in that order at each edge.
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no request pending: status %0d read_value %h",
                 out_data.status, out_data.read_value);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %h actual %h", want.read_value, out_data.read_value);
            mismatches++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (cfg_we) load_limit_now = cfg_data;
      if (in_valid && !in_stall) begin
        want = map_apply(in_data);
        pending_results.push_back(req_typed ? req_want : want);
      end
    end
  end

  // Receiver: short stall runs, long open stretches, and one long hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      run_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end else begin
      out_stall <= 1'b1;
      run_left <= $urandom_range(0, 3);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) key_pool[i] = (i % 3 == 0) ? {$urandom, $urandom} : crowded_key();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_LIMIT) begin
        write_limit(directed[i].limit);
      end else begin
        offer('{mode: directed[i].mode, key: directed[i].key, set_value: directed[i].value},
              directed[i].typed,
              '{status: directed[i].status, read_value: directed[i].read_value});
      end
    end

    // Random phases, each under its own load limit.
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      refresh_pool(12);
      for (int n = 0; n < PHASE_ITEMS; n++) offer(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/oahm_pkg.sv
rtl/core/oahm_ram.sv
rtl/core/oahm_home.sv
rtl/core/open_addressing_hash_map.sv
sim/open_addressing_hash_map_tb.sv
